/* hw/rtl/rbvs_pkg.sv */
// Package for the rigid body Verlet step core: opcodes, state codes,
// constants and the shared saturation helper. No dependencies.
`default_nettype none
package rbvs_pkg;
   typedef enum logic [1:0] {
      OP_ADD_FORCE = 2'd0,
      OP_SET_VEL   = 2'd1,
      OP_SET_POS   = 2'd2,
      OP_STEP      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_INV_MASS  = 2'd0,
      CSR_VERT_FORCE = 2'd1,
      CSR_DRAG      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NEXT,
      ST_DONE
   } state_type;

   localparam int unsigned MUL_A_W   = 65;
   localparam int unsigned MUL_B_W   = 32;
   localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
   localparam int unsigned MUL_CNT_W = 6;
   localparam logic [31:0] TENTH_Q16 = 32'd6554;

   function automatic logic [31:0] sat32(input logic signed [67:0] v);
      logic [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/rbvs_serial_mul.sv */
// Bit-serial unsigned multiplier: one multiplier bit per cycle, one shift-add.
// Depends on rbvs_pkg for widths.
`default_nettype none
module rbvs_serial_mul (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [rbvs_pkg::MUL_A_W-1:0]       mcand,
   input  wire logic [rbvs_pkg::MUL_B_W-1:0]       mplier,
   output logic                                    done,
   output logic [rbvs_pkg::PROD_W-1:0]             product
);
   logic [rbvs_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [rbvs_pkg::MUL_B_W-1:0]  mpl_ff, mpl_in;
   logic [rbvs_pkg::MUL_A_W-1:0]  mca_ff, mca_in;
   logic [rbvs_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [rbvs_pkg::MUL_A_W:0]    sum;

   // Upper part accumulates; product shifts right one bit per cycle.
   always_comb begin
      sum = {1'b0, acc_ff[rbvs_pkg::PROD_W-1:rbvs_pkg::MUL_B_W]}
          + (mpl_ff[0] ? {1'b0, mca_ff} : '0);
      acc_in  = acc_ff;
      mpl_in  = mpl_ff;
      mca_in  = mca_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done    = 1'b0;
      if (start) begin
         acc_in  = '0;
         mpl_in  = mplier;
         mca_in  = mcand;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[rbvs_pkg::MUL_B_W-1:1]};
         mpl_in = mpl_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rbvs_pkg::MUL_CNT_W'(rbvs_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mpl_ff <= mpl_in;
      mca_ff <= mca_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign product = acc_in;
endmodule
`default_nettype wire

/* hw/rtl/rigid_body_verlet_step_core.sv */
// Top level of the rigid body Verlet step core: state, sequencer, request
// and response channels. Depends on rbvs_pkg and rbvs_serial_mul.
// Add, set velocity and set position raise the response in the cycle after
// the request is taken; the next request waits until that response is taken.
// A step runs 22 multiplications on a bit-serial multiplier and raises its
// response once all three components are done.
// One request is in work at a time and a waiting response holds off the next.
// Synchronous reset clears state to zero and registers to their defaults.
`default_nettype none
module rigid_body_verlet_step_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_vec_x,
   input  wire logic signed [31:0] req_vec_y,
   input  wire logic signed [31:0] req_vec_z,
   input  wire logic [23:0]        req_time_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic signed [31:0]      rsp_vel_x,
   output logic signed [31:0]      rsp_vel_y,
   output logic signed [31:0]      rsp_vel_z,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   logic [30:0] inv_mass_ff;
   logic [31:0] vert_ff;
   logic [30:0] drag_ff;

   logic [31:0] pos_ff [3];
   logic [31:0] vel_ff [3];
   logic [31:0] acc_ff [3];
   logic [31:0] frc_ff [3];
   logic [31:0] pos_in [3];
   logic [31:0] vel_in [3];
   logic [31:0] acc_in [3];
   logic [31:0] frc_in [3];

   rbvs_pkg::state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;   // operation within a component
   logic [1:0]  comp_ff, comp_in;
   logic [23:0] dt_ff, dt_in;
   logic [31:0] dt2_ff, dt2_in;
   logic signed [67:0] t_ff, t_in;  // running value for the component
   logic signed [67:0] u_ff, u_in;  // second scratch
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mul_start, mul_done;
   logic [rbvs_pkg::MUL_A_W-1:0] mul_a;
   logic [rbvs_pkg::MUL_B_W-1:0] mul_b;
   logic [rbvs_pkg::PROD_W-1:0]  mul_p;
   logic        neg;
   logic [rbvs_pkg::MUL_A_W-1:0] mag;
   logic signed [67:0] sv;

   rbvs_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .product(mul_p)
   );

   // Signed operand of the current multiply, taken on its magnitude.
   always_comb begin
      logic [31:0] vv;
      vv = vel_ff[comp_ff];
      sv = '0;
      mul_b = '0;
      case (step_ff)
         4'd0: begin sv = 68'(signed'(vv)); mul_b = 32'(vv[31] ? -vv : vv); end
         4'd1: begin sv = 68'(t_ff[32:0]); mul_b = {1'b0, drag_ff}; end
         4'd2: begin sv = 68'(signed'(vv)); mul_b = {8'd0, dt_ff}; end
         4'd3: begin sv = 68'(signed'(acc_ff[comp_ff])); mul_b = dt2_ff; end
         4'd4: begin sv = 68'(signed'(u_ff[31:0])); mul_b = {1'b0, inv_mass_ff}; end
         4'd5: begin sv = u_ff; mul_b = {8'd0, dt_ff}; end
         4'd6: begin sv = 68'(signed'(u_ff[31:0])); mul_b = rbvs_pkg::TENTH_Q16; end
         4'd7: begin sv = 68'(dt_ff); mul_b = {8'd0, dt_ff}; end
         default: begin sv = '0; mul_b = '0; end
      endcase
      neg = sv[67];
      mag = rbvs_pkg::MUL_A_W'(neg ? -sv : sv);
      mul_a = mag;
   end

   always_comb begin
      logic [rbvs_pkg::PROD_W-1:0] sh;
      logic signed [67:0] r16, r17;
      logic [32:0] sq;
      logic [31:0] f;
      sh  = mul_p >> 16;
      r16 = neg ? -68'(sh) : 68'(sh);
      sh  = mul_p >> 17;
      r17 = neg ? -68'(sh) : 68'(sh);
      sq  = (mul_p[rbvs_pkg::PROD_W-1:48] != '0) ? 33'h0_ffff_ffff : {1'b0, mul_p[47:16]};
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         vel_in[i] = vel_ff[i];
         acc_in[i] = acc_ff[i];
         frc_in[i] = frc_ff[i];
      end
      state_in     = state_ff;
      step_in      = step_ff;
      comp_in      = comp_ff;
      dt_in        = dt_ff;
      dt2_in       = dt2_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_start    = 1'b0;
      req_stall    = (state_ff != rbvs_pkg::ST_IDLE) || rsp_valid_ff;
      f            = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         rbvs_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (rbvs_pkg::opcode_type'(req_opcode))
                  rbvs_pkg::OP_ADD_FORCE: begin
                     frc_in[0] = rbvs_pkg::sat32(68'(signed'(frc_ff[0])) + 68'(req_vec_x));
                     frc_in[1] = rbvs_pkg::sat32(68'(signed'(frc_ff[1])) + 68'(req_vec_y));
                     frc_in[2] = rbvs_pkg::sat32(68'(signed'(frc_ff[2])) + 68'(req_vec_z));
                     rsp_valid_in = 1'b1;
                  end
                  rbvs_pkg::OP_SET_VEL: begin
                     vel_in[0] = req_vec_x; vel_in[1] = req_vec_y; vel_in[2] = req_vec_z;
                     rsp_valid_in = 1'b1;
                  end
                  rbvs_pkg::OP_SET_POS: begin
                     pos_in[0] = req_vec_x; pos_in[1] = req_vec_y; pos_in[2] = req_vec_z;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     dt_in    = req_time_step;
                     comp_in  = 2'd0;
                     step_in  = 4'd7;
                     state_in = rbvs_pkg::ST_NEXT;
                  end
               endcase
            end
         end
         rbvs_pkg::ST_NEXT: begin
            mul_start = 1'b1;
            state_in  = rbvs_pkg::ST_MUL;
         end
         rbvs_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = rbvs_pkg::ST_NEXT;
               case (step_ff)
                  4'd7: begin
                     dt2_in  = mul_p[47:16];
                     step_in = 4'd0;
                  end
                  4'd0: begin
                     t_in    = 68'(sq);
                     step_in = 4'd1;
                  end
                  4'd1: begin
                     // Drag opposes motion; t held |v|^2 unsigned.
                     u_in = 68'(signed'(frc_ff[comp_ff]))
                          + (vel_ff[comp_ff][31] ? 68'(mul_p >> 17) : -68'(mul_p >> 17))
                          + ((comp_ff == 2'd1) ? 68'(signed'(vert_ff)) : 68'sd0);
                     u_in = 68'(signed'(rbvs_pkg::sat32(u_in)));
                     t_in = 68'(signed'(pos_ff[comp_ff]));
                     step_in = 4'd2;
                  end
                  4'd2: begin
                     t_in = t_ff + r16;
                     step_in = 4'd3;
                  end
                  4'd3: begin
                     pos_in[comp_ff] = rbvs_pkg::sat32(t_ff + r17);
                     step_in = 4'd4;
                  end
                  4'd4: begin
                     f = rbvs_pkg::sat32(r16);
                     acc_in[comp_ff] = f;
                     u_in = 68'(signed'(acc_ff[comp_ff])) + 68'(signed'(f));
                     step_in = 4'd5;
                  end
                  4'd5: begin
                     u_in = 68'(signed'(rbvs_pkg::sat32(68'(signed'(vel_ff[comp_ff])) + r17)));
                     frc_in[comp_ff] = '0;
                     step_in = 4'd6;
                  end
                  default: begin
                     vel_in[comp_ff] = r16[31:0];
                     step_in = 4'd0;
                     if (comp_ff == 2'd2) begin
                        state_in     = rbvs_pkg::ST_DONE;
                     end else begin
                        comp_in = comp_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         rbvs_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = rbvs_pkg::ST_IDLE;
         end
         default: state_in = rbvs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dt_ff  <= dt_in;
      dt2_ff <= dt2_in;
      t_ff   <= t_in;
      u_ff   <= u_in;
      if (reset) begin
         state_ff     <= rbvs_pkg::ST_IDLE;
         step_ff      <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         inv_mass_ff  <= 31'd65536;
         vert_ff      <= '0;
         drag_ff      <= 31'd65536;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
            acc_ff[i] <= acc_in[i];
            frc_ff[i] <= frc_in[i];
         end
         if (csr_write) begin
            case (rbvs_pkg::csr_index_type'(csr_index))
               rbvs_pkg::CSR_INV_MASS:   inv_mass_ff <= csr_data[30:0];
               rbvs_pkg::CSR_VERT_FORCE: vert_ff     <= csr_data;
               rbvs_pkg::CSR_DRAG:       drag_ff     <= csr_data[30:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];
   assign rsp_vel_z = vel_ff[2];
endmodule
`default_nettype wire
